>>> rtl/ljed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ljed_pkg
// Shared types, constants and helpers of the Lennard-Jones energy delta unit.
// ----------------------------------------------------------------------------
package ljed_pkg;

  localparam int COORD_W   = 24;
  localparam int IDX_W     = 8;
  localparam int ENERGY_W  = 48;
  localparam int R2_W      = 48;
  localparam int RECIP_W   = 28;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQUARED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRUNCATE       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 2'd3;

  localparam logic signed [ENERGY_W-1:0] E_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ENERGY_W-1:0] E_MIN = -48'sh8000_0000_0000;

  typedef logic [2:0][COORD_W-1:0] coord3_t;

  typedef struct packed {
    logic             is_query;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    coord3_t          pos;
  } item_t;

  // minimum image magnitude of a - b, both already reduced below len
  function automatic logic [COORD_W-1:0] img_mag(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b,
                                                 input logic [COORD_W-1:0] len);
    logic [COORD_W:0]   d;
    logic [COORD_W-1:0] dd;
    logic [COORD_W-1:0] ld;
    if (a >= b) begin
      d = {1'b0, a} - {1'b0, b};
    end else begin
      d = {1'b0, a} + {1'b0, len} - {1'b0, b};
    end
    dd = d[COORD_W-1:0];
    ld = len - dd;
    return (dd <= ld) ? dd : ld;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ljed_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ljed_front
// Input acceptor: classifies each transaction and holds it in a two-entry
// queue ahead of the sequencer.
// ----------------------------------------------------------------------------
module ljed_front #(
  parameter int MAX_PARTICLES = 256
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire  [79:0]          s_tdata,
  input  wire                  s_tuser,
  output logic                 q_valid,
  output ljed_pkg::item_t      q_item,
  input  wire                  q_pop
);
  import ljed_pkg::*;

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      in_item;
  logic       push;

  always_comb begin
    in_item.is_query = s_tuser;
    in_item.idx      = s_tdata[7:0];
    in_item.in_range = (32'(s_tdata[7:0]) < 32'(MAX_PARTICLES));
    in_item.pos[0]   = s_tdata[31:8];
    in_item.pos[1]   = s_tdata[55:32];
    in_item.pos[2]   = s_tdata[79:56];
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/ljed_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ljed_mod
// Three-lane restoring modulo: reduces x, y and z by the box edge, one bit
// per cycle, done pulses after 24 steps.
// ----------------------------------------------------------------------------
module ljed_mod (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire  ljed_pkg::coord3_t     a,
  input  wire  [ljed_pkg::COORD_W-1:0] len,
  output logic                        done,
  output ljed_pkg::coord3_t           res
);
  import ljed_pkg::*;

  logic          busy;
  logic [4:0]    cnt;
  coord3_t       src;
  coord3_t       rem;
  coord3_t       rem_next;
  logic [COORD_W:0] t;

  always_comb begin
    rem_next = rem;
    t        = '0;
    for (int k = 0; k < 3; k++) begin
      t = {rem[k], src[k][cnt]};
      if (t >= {1'b0, len}) begin
        t = t - {1'b0, len};
      end
      rem_next[k] = t[COORD_W-1:0];
    end
  end

  assign res = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(COORD_W - 1);
        src  <= a;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/ljed_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ljed_div
// Reciprocal unit: floor(2^56 / den) for den above 2^28, restoring, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module ljed_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  [ljed_pkg::R2_W-1:0]    den,
  output logic                         done,
  output logic [ljed_pkg::RECIP_W-1:0] quo
);
  import ljed_pkg::*;

  logic            busy;
  logic [4:0]      cnt;
  logic [R2_W-1:0] d;
  logic [R2_W-1:0] rem;
  logic [R2_W:0]   t;
  logic            take;

  // partial remainder stays below den, so the shifted value fits R2_W+1 bits
  assign t    = {rem, 1'b0};
  assign take = (t >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(RECIP_W - 1);
        d    <= den;
        rem  <= R2_W'(1) << RECIP_W;
        quo  <= '0;
      end else if (busy) begin
        rem <= take ? R2_W'(t - {1'b0, d}) : t[R2_W-1:0];
        quo <= {quo[RECIP_W-2:0], take};
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/ljed_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ljed_core
// Back end: position table, pair walk, r^2 and pair energy evaluation,
// saturating sum and the output register.
// ----------------------------------------------------------------------------
module ljed_core #(
  parameter int MAX_PARTICLES = 256,
  parameter int COORD_BITS    = 24
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            q_valid,
  input  wire  ljed_pkg::item_t          q_item,
  output logic                           q_pop,
  input  wire  [ljed_pkg::COORD_W-1:0]   box_length,
  input  wire  [31:0]                    cutoff_squared,
  input  wire                            truncate_enable,
  input  wire  [8:0]                     particle_count,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [ljed_pkg::ENERGY_W-1:0]  out_energy,
  output logic                           out_sat
);
  import ljed_pkg::*;

  localparam int IW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int XW = (CW > 9) ? CW : 9;
  localparam int SW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_OLD  = 5'd1;
  localparam logic [4:0] S_NMOD = 5'd2;
  localparam logic [4:0] S_OMOD = 5'd3;
  localparam logic [4:0] S_JNXT = 5'd4;
  localparam logic [4:0] S_JRD  = 5'd5;
  localparam logic [4:0] S_JMOD = 5'd6;
  localparam logic [4:0] S_SQM  = 5'd7;
  localparam logic [4:0] S_SQA  = 5'd8;
  localparam logic [4:0] S_PE   = 5'd9;
  localparam logic [4:0] S_DIV  = 5'd10;
  localparam logic [4:0] S_M1   = 5'd11;
  localparam logic [4:0] S_M2   = 5'd12;
  localparam logic [4:0] S_M3   = 5'd13;
  localparam logic [4:0] S_M4   = 5'd14;
  localparam logic [4:0] S_M5   = 5'd15;
  localparam logic [4:0] S_M6   = 5'd16;
  localparam logic [4:0] S_M7   = 5'd17;
  localparam logic [4:0] S_M8   = 5'd18;
  localparam logic [4:0] S_TERM = 5'd19;
  localparam logic [4:0] S_DONE = 5'd20;

  logic [4:0]        state;

  // position table
  logic [3*SW-1:0]   mem [MAX_PARTICLES];
  logic [3*SW-1:0]   rd_q;
  logic [IW-1:0]     mem_ra;
  logic              mem_we;
  logic [3*SW-1:0]   mem_wd;
  coord3_t           rd_c;
  coord3_t           in_m;

  // walk state
  coord3_t           np_raw, old_raw, np_m, old_m, pj_m;
  logic [IDX_W-1:0]  idx_r;
  logic [CW-1:0]     cnt_lim;
  logic [CW-1:0]     j;
  logic [1:0]        sq_ax;
  logic              side;
  logic [R2_W-1:0]   r2n, r2o, r2s;
  logic [COORD_W-1:0] len_e, mag;

  // pair energy datapath
  logic [RECIP_W-1:0] s;
  logic [31:0]        s2;
  logic [34:0]        s3;
  logic [35:0]        s3_full;
  logic [52:0]        lo_p;
  logic [70:0]        s6_full;
  logic [45:0]        s6;
  logic signed [49:0] e_full;
  logic signed [ENERGY_W-1:0] term, en, sum;
  logic signed [49:0] sum_full;
  logic               sat;

  logic [34:0]        mul_a;
  logic [27:0]        mul_b;
  logic [62:0]        mul_p;

  logic               mod_start, mod_done, div_start, div_done;
  coord3_t            mod_a, mod_res;
  logic [RECIP_W-1:0] div_q;

  assign len_e = (box_length == '0) ? COORD_W'(1) : box_length;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_c[k] = COORD_W'(rd_q[k*SW +: SW]);
      in_m[k] = COORD_W'(q_item.pos[k][SW-1:0]);
    end
  end

  assign q_pop  = (state == S_IDLE) && q_valid;
  assign mem_we = q_pop && !q_item.is_query && q_item.in_range;
  assign mem_ra = (state == S_IDLE) ? IW'(q_item.idx) : j[IW-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mem_wd[k*SW +: SW] = q_item.pos[k][SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[IW'(q_item.idx)] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  // modulo and divider hand-off
  always_comb begin
    mod_start = 1'b0;
    mod_a     = rd_c;
    unique case (state)
      S_OLD: begin
        mod_start = 1'b1;
        mod_a     = np_raw;
      end
      S_NMOD: begin
        mod_start = mod_done;
        mod_a     = old_raw;
      end
      S_JRD:   mod_start = 1'b1;
      default: mod_start = 1'b0;
    endcase
  end

  assign mag = side ? img_mag(old_m[sq_ax], pj_m[sq_ax], len_e)
                    : img_mag(np_m[sq_ax], pj_m[sq_ax], len_e);
  assign r2s = side ? r2o : r2n;

  logic trunc_hit, close_hit;
  assign trunc_hit = truncate_enable && (r2s >= {cutoff_squared, 16'd0});
  assign close_hit = (r2s <= (R2_W'(1) << 28));
  assign div_start = (state == S_PE) && !trunc_hit && !close_hit;

  // single shared multiplier, product registered
  always_comb begin
    unique case (state)
      S_SQM: begin
        mul_a = 35'(mag);
        mul_b = 28'(mag);
      end
      S_M1: begin
        mul_a = 35'(s);
        mul_b = s;
      end
      S_M3: begin
        mul_a = 35'(s2);
        mul_b = s;
      end
      S_M5: begin
        mul_a = s3;
        mul_b = 28'(s3[17:0]);
      end
      S_M6: begin
        mul_a = s3;
        mul_b = 28'(s3[34:18]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= 63'(mul_a) * 63'(mul_b);
  end

  assign s3_full  = mul_p[59:24];
  assign s6_full  = {1'b0, mul_p[51:0], 18'd0} + 71'(lo_p);
  assign e_full   = ($signed({4'd0, s6}) - $signed({15'd0, s3})) <<< 2;
  assign sum_full = 50'(sum) + 50'(en) - 50'(term);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a result leaving while the next is loaded keeps valid high
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_item.is_query) begin
            sum     <= '0;
            sat     <= 1'b0;
            np_raw  <= in_m;
            idx_r   <= q_item.idx;
            cnt_lim <= (XW'(particle_count) > XW'(MAX_PARTICLES))
                       ? CW'(MAX_PARTICLES) : CW'(particle_count);
            state   <= q_item.in_range ? S_OLD : S_DONE;
          end
        end
        S_OLD: begin
          old_raw <= rd_c;
          state   <= S_NMOD;
        end
        S_NMOD: begin
          if (mod_done) begin
            np_m  <= mod_res;
            state <= S_OMOD;
          end
        end
        S_OMOD: begin
          if (mod_done) begin
            old_m <= mod_res;
            j     <= '0;
            state <= S_JNXT;
          end
        end
        S_JNXT: begin
          if (j >= cnt_lim) begin
            state <= S_DONE;
          end else if (XW'(j) == XW'(idx_r)) begin
            j <= j + CW'(1);
          end else begin
            state <= S_JRD;
          end
        end
        S_JRD: state <= S_JMOD;
        S_JMOD: begin
          if (mod_done) begin
            pj_m  <= mod_res;
            sq_ax <= 2'd0;
            side  <= 1'b0;
            r2n   <= '0;
            r2o   <= '0;
            state <= S_SQM;
          end
        end
        S_SQM: state <= S_SQA;
        S_SQA: begin
          if (side) begin
            r2o <= r2o + mul_p[R2_W-1:0];
          end else begin
            r2n <= r2n + mul_p[R2_W-1:0];
          end
          if (sq_ax == 2'd2) begin
            sq_ax <= 2'd0;
            side  <= ~side;
            state <= side ? S_PE : S_SQM;
          end else begin
            sq_ax <= sq_ax + 2'd1;
            state <= S_SQM;
          end
        end
        S_PE: begin
          if (trunc_hit) begin
            term  <= '0;
            state <= S_TERM;
          end else if (close_hit) begin
            term  <= E_MAX;
            sat   <= 1'b1;
            state <= S_TERM;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            s     <= div_q;
            state <= S_M1;
          end
        end
        S_M1: state <= S_M2;
        S_M2: begin
          s2    <= mul_p[55:24];
          state <= S_M3;
        end
        S_M3: state <= S_M4;
        S_M4: begin
          if (s3_full[35]) begin
            term  <= E_MAX;
            sat   <= 1'b1;
            state <= S_TERM;
          end else begin
            s3    <= s3_full[34:0];
            state <= S_M5;
          end
        end
        S_M5: state <= S_M6;
        S_M6: begin
          lo_p  <= mul_p[52:0];
          state <= S_M7;
        end
        S_M7: begin
          s6    <= s6_full[69:24];
          state <= S_M8;
        end
        S_M8: begin
          if (e_full > 50'(E_MAX)) begin
            term <= E_MAX;
            sat  <= 1'b1;
          end else begin
            term <= e_full[ENERGY_W-1:0];
          end
          state <= S_TERM;
        end
        S_TERM: begin
          if (!side) begin
            en    <= term;
            side  <= 1'b1;
            state <= S_PE;
          end else begin
            if (sum_full > 50'(E_MAX)) begin
              sum <= E_MAX;
              sat <= 1'b1;
            end else if (sum_full < 50'(E_MIN)) begin
              sum <= E_MIN;
              sat <= 1'b1;
            end else begin
              sum <= sum_full[ENERGY_W-1:0];
            end
            side  <= 1'b0;
            j     <= j + CW'(1);
            state <= S_JNXT;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            out_energy <= sum;
            out_sat    <= sat;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ljed_mod u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .a     (mod_a),
    .len   (len_e),
    .done  (mod_done),
    .res   (mod_res)
  );

  ljed_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .den   (r2s),
    .done  (div_done),
    .quo   (div_q)
  );

endmodule
`default_nettype wire

>>> rtl/lennard_jones_energy_delta_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lennard_jones_energy_delta_unit
// Fixed-point Lennard-Jones energy change of a trial move in a periodic box.
// ----------------------------------------------------------------------------
// Usage:
//  s_* stream carries items: tuser = op (0 write position, 1 query), tdata =
//  particle index and x, y, z in Q8.16. A write stores the position and gives
//  no result. A query walks every other particle in use and returns the
//  energy change (Q24.24) on m_tdata with the saturation flag on m_tuser.
//  cfg_* writes box_length, cutoff_squared, truncate_enable, particle_count
//  by index; it is always ready and should be used only while idle.
//  A write is stored from the queue while the back end is idle. The time
//  a query takes is set by the bit-serial modulo (once per fetched
//  position) and the reciprocal divider (once per pair term, two terms
//  per pair); a term that is cut off or close enough to saturate at once
//  skips the divider and the multiplies.
//  A two-entry queue keeps s_tready high while the back end works until it
//  fills, and the output register holds a result until m_tready; the back
//  end then waits.
//  Reset loads the register defaults and empties queue and output; the
//  position table is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
module lennard_jones_energy_delta_unit #(
  parameter int MAX_PARTICLES = 256,
  parameter int COORD_BITS    = 24
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [79:0] s_tdata,   // particle_index, pos_x, pos_y, pos_z
  input  wire         s_tuser,   // op
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [47:0] m_tdata,   // energy_diff
  output logic        m_tuser,   // saturated
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import ljed_pkg::*;

  logic [COORD_W-1:0] box_length;
  logic [31:0]        cutoff_squared;
  logic               truncate_enable;
  logic [8:0]         particle_count;
  logic               q_valid;
  logic               q_pop;
  item_t              q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_length      <= 24'd524288;
      cutoff_squared  <= 32'd409600;
      truncate_enable <= 1'b1;
      particle_count  <= 9'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOX_LENGTH:     box_length      <= cfg_data[COORD_W-1:0];
        REG_CUTOFF_SQUARED: cutoff_squared  <= cfg_data;
        REG_TRUNCATE:       truncate_enable <= cfg_data[0];
        REG_PARTICLE_COUNT: particle_count  <= cfg_data[8:0];
        default:            box_length      <= box_length;
      endcase
    end
  end

  ljed_front #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  ljed_core #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .COORD_BITS    (COORD_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .box_length      (box_length),
    .cutoff_squared  (cutoff_squared),
    .truncate_enable (truncate_enable),
    .particle_count  (particle_count),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_energy      (m_tdata),
    .out_sat         (m_tuser)
  );

endmodule
`default_nettype wire

>>> rtl/ljed_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ljed_checker
// Port-level checks of the energy delta unit, bound to the top level.
// ----------------------------------------------------------------------------
module ljed_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [47:0] m_tdata,
  input wire        m_tuser,
  input wire        cfg_ready
);

  // reset empties the queue and the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("queue or output not empty after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

  // configuration never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind lennard_jones_energy_delta_unit ljed_checker u_ljed_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .cfg_ready (cfg_ready)
);
`default_nettype wire

>>> bench/lennard_jones_energy_delta_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lennard_jones_energy_delta_unit_tb
// Self-checking bench for the LJ energy delta unit. It fills the position
// table, then runs directed and random writes and trial-move queries under
// several box, cutoff and particle-count settings. Random input gaps and
// result back-pressure are applied. Every energy delta and saturation flag
// is predicted and checked in order.
// ----------------------------------------------------------------------------
module lennard_jones_energy_delta_unit_tb;
  import ljed_pkg::*;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam int  TABLE_SIZE = 256;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct {
    logic [47:0] energy;
    logic        sat;
  } energy_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: private copy of table and registers, queue of expected deltas
  // --------------------------------------------------------------------------
  class energy_delta_scoreboard;
    logic [23:0]    positions [TABLE_SIZE][3];
    logic [23:0]    box_len;
    logic [31:0]    cutoff_sq;
    logic           trunc_en;
    logic [8:0]     count;
    energy_result_t pending_deltas [$];
    int             mismatches;
    int             results_seen;
    int             saturated_seen;
    int             writes_seen;

    function void reset_state();
      box_len   = 24'd524288;
      cutoff_sq = 32'd409600;
      trunc_en  = 1'b1;
      count     = 9'd0;
      foreach (positions[i, k]) positions[i][k] = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_BOX_LENGTH:     box_len   = value[23:0];
        REG_CUTOFF_SQUARED: cutoff_sq = value;
        REG_TRUNCATE:       trunc_en  = value[0];
        REG_PARTICLE_COUNT: count     = value[8:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] mul_q24(logic [63:0] a, logic [63:0] b);
      return (a >> 24) * b + (((a & 64'hFF_FFFF) * b) >> 24);
    endfunction

    function logic [63:0] separation_sq(logic [23:0] p [3], logic [23:0] q [3]);
      logic [63:0] len;
      logic [63:0] am;
      logic [63:0] bm;
      logic [63:0] d;
      logic [63:0] mag;
      logic [64:0] total;
      len   = (box_len == 0) ? 64'd1 : 64'(box_len);
      total = '0;
      for (int k = 0; k < 3; k++) begin
        am  = 64'(p[k]) % len;
        bm  = 64'(q[k]) % len;
        d   = (am >= bm) ? am - bm : am + len - bm;
        mag = (d <= len - d) ? d : len - d;
        total = total + 65'(mag * mag);
        if (total[64]) total = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
      end
      return total[63:0];
    endfunction

    function longint pair_term(logic [63:0] r2, inout logic sat);
      logic [63:0] s;
      logic [63:0] s2;
      logic [63:0] s3;
      logic [63:0] s6;
      longint      e;
      if (trunc_en && r2 >= (64'(cutoff_sq) << 16)) return 0;
      if (r2 <= (64'd1 << 28)) begin
        sat = 1'b1;
        return longint'(E_MAX);
      end
      s  = (64'd1 << 56) / r2;
      s2 = mul_q24(s, s);
      s3 = mul_q24(s2, s);
      if (s3 >= (64'd1 << 35)) begin
        sat = 1'b1;
        return longint'(E_MAX);
      end
      s6 = mul_q24(s3, s3);
      e  = 4 * ($signed(s6) - $signed(s3));
      if (e > longint'(E_MAX)) begin
        sat = 1'b1;
        e   = longint'(E_MAX);
      end
      return e;
    endfunction

    function void note_input(logic op, logic [7:0] idx, logic [23:0] pos [3]);
      longint         total;
      longint         en;
      longint         eo;
      int             n;
      energy_result_t r;
      logic           sat;
      if (op == OP_WRITE) begin
        positions[idx] = pos;
        writes_seen++;
        return;
      end
      total = 0;
      sat   = 1'b0;
      n     = (count > TABLE_SIZE) ? TABLE_SIZE : int'(count);
      for (int j = 0; j < n; j++) begin
        if (j == idx) continue;
        en = pair_term(separation_sq(pos, positions[j]), sat);
        eo = pair_term(separation_sq(positions[idx], positions[j]), sat);
        total += en - eo;
        if (total > longint'(E_MAX)) begin total = longint'(E_MAX); sat = 1'b1; end
        if (total < longint'(E_MIN)) begin total = longint'(E_MIN); sat = 1'b1; end
      end
      r.energy = total[47:0];
      r.sat    = sat;
      pending_deltas.insert(pending_deltas.size(), r);
    endfunction

    function void check_result(logic [47:0] energy, logic sat);
      energy_result_t exp_r;
      results_seen++;
      if (sat) saturated_seen++;
      if (pending_deltas.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result energy=%h sat=%b", energy, sat);
        return;
      end
      exp_r = pending_deltas.pop_front();
      if (exp_r.energy !== energy || exp_r.sat !== sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d expected energy=%h sat=%b, got energy=%h sat=%b",
                   results_seen, exp_r.energy, exp_r.sat, energy, sat);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // particle_index, pos_x, pos_y, pos_z
  logic        s_tuser = 1'b0; // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // energy_diff
  logic        m_tuser;        // saturated
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  energy_delta_scoreboard sb;
  longint cycles = 0;
  bit     idle_on = 1'b0;
  int     hold_cycles = 0;
  int     ready_wait = 0;

  lennard_jones_energy_delta_unit u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tuser);
      ready_wait = idle_on ? $urandom_range(0, 16) : 0;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles--;
    end else if (ready_wait > 0) begin
      m_tready <= 1'b0;
      ready_wait--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  task automatic send_item(logic op, logic [7:0] idx, logic [23:0] pos [3]);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {pos[2], pos[1], pos[0], idx};
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, idx, pos);
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_deltas.size() != 0) @(posedge clk);
    // a trailing position write may still be in the back end
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_phase(logic [23:0] len, logic [31:0] cut, logic trunc, logic [8:0] n);
    stop_sending();
    wait_drained();
    write_reg(REG_BOX_LENGTH, {8'd0, len});
    write_reg(REG_CUTOFF_SQUARED, cut);
    write_reg(REG_TRUNCATE, {31'd0, trunc});
    write_reg(REG_PARTICLE_COUNT, {23'd0, n});
  endtask

  function automatic logic [23:0] pick_coord(logic [23:0] len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80 && len > 1) return 24'($urandom_range(0, int'(len) - 1));
    if (r < 90) return 24'($urandom);
    return (r < 95) ? 24'h0 : 24'hFF_FFFF;
  endfunction

  // mostly writes and queries aimed at particles in use, with some noise
  task automatic random_items(int n_items);
    logic [23:0] pos [3];
    logic        op;
    logic [7:0]  idx;
    int          lim;
    lim = (sb.count == 0) ? 0 : ((sb.count > TABLE_SIZE) ? TABLE_SIZE - 1 : sb.count - 1);
    for (int i = 0; i < n_items; i++) begin
      op  = ($urandom_range(0, 99) < 55) ? OP_QUERY : OP_WRITE;
      idx = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, lim)) : 8'($urandom);
      for (int k = 0; k < 3; k++) pos[k] = pick_coord(sb.box_len);
      // land exactly on a neighbour now and then
      if ($urandom_range(0, 19) == 0) pos = sb.positions[$urandom_range(0, lim)];
      send_item(op, idx, pos);
    end
  endtask

  // --------------------------------------------------------------------------
  initial begin
    logic [23:0] pos [3];
    int          queries_sent;
    sb = new();
    sb.reset_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill the whole table so that no query reads an unwritten entry
    for (int i = 0; i < TABLE_SIZE; i++) begin
      for (int k = 0; k < 3; k++) pos[k] = 24'($urandom_range(0, 524287));
      send_item(OP_WRITE, 8'(i), pos);
    end

    // directed: zero distance, own position, particle not in use, extremes
    set_phase(24'd524288, 32'd409600, 1'b1, 9'd4);
    send_item(OP_QUERY, 8'd0, sb.positions[1]);
    send_item(OP_QUERY, 8'd2, sb.positions[2]);
    send_item(OP_QUERY, 8'd200, sb.positions[3]);
    pos = '{24'h0, 24'h0, 24'h0};
    send_item(OP_QUERY, 8'd1, pos);
    pos = '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF};
    send_item(OP_QUERY, 8'd3, pos);
    send_item(OP_WRITE, 8'd255, pos);
    send_item(OP_QUERY, 8'd255, sb.positions[0]);
    pos = '{24'h01_0000, 24'h0, 24'h0};
    send_item(OP_WRITE, 8'd1, pos);
    pos = '{24'h02_0000, 24'h0, 24'h0};
    send_item(OP_QUERY, 8'd0, pos);
    pos = '{24'h00_0100, 24'h0, 24'h0};
    send_item(OP_QUERY, 8'd0, pos);
    set_phase(24'd524288, 32'd409600, 1'b0, 9'd0);
    send_item(OP_QUERY, 8'd0, pos);
    set_phase(24'd1, 32'd0, 1'b0, 9'd3);
    send_item(OP_QUERY, 8'd1, pos);
    set_phase(24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1, 9'd3);
    send_item(OP_QUERY, 8'd0, pos);
    send_item(OP_QUERY, 8'd2, sb.positions[1]);

    // random phases across register settings
    idle_on = 1'b1;
    set_phase(24'd196608, 32'd409600, 1'b1, 9'd4);
    random_items(120);
    set_phase(24'd262144, 32'd0, 1'b1, 9'd5);
    random_items(90);
    idle_on = 1'b0;
    set_phase(24'd327680, 32'hFFFF_FFFF, 1'b0, 9'd3);
    random_items(90);
    idle_on = 1'b1;
    set_phase(24'd131072, 32'd262144, 1'b1, 9'd6);
    random_items(100);
    set_phase(24'hFF_FFFF, 32'd409600, 1'b0, 9'd4);
    random_items(80);
    set_phase(24'd1, 32'd1000, 1'b1, 9'd2);
    random_items(60);
    set_phase(24'($urandom_range(65536, 1048576)), $urandom, 1'b0, 9'd5);
    random_items(100);

    // receiver holds off long enough for the input queue to fill
    set_phase(24'd196608, 32'd409600, 1'b1, 9'd2);
    hold_cycles = 4000;
    queries_sent = 0;
    while (queries_sent < 12) begin
      for (int k = 0; k < 3; k++) pos[k] = pick_coord(sb.box_len);
      send_item(OP_QUERY, 8'($urandom_range(0, 1)), pos);
      queries_sent++;
    end
    random_items(60);

    // full table, a couple of long walks
    idle_on = 1'b0;
    set_phase(24'd524288, 32'd409600, 1'b1, 9'd256);
    for (int k = 0; k < 3; k++) pos[k] = 24'($urandom_range(0, 524287));
    send_item(OP_QUERY, 8'd255, pos);
    set_phase(24'd524288, 32'd409600, 1'b0, 9'd256);
    send_item(OP_QUERY, 8'd17, sb.positions[18]);

    idle_on = 1'b1;
    set_phase(24'd393216, 32'd655360, 1'b1, 9'd4);
    random_items(140);

    stop_sending();
    while (sb.pending_deltas.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d position writes and %0d queries (%0d saturated results)",
             sb.writes_seen, sb.results_seen, sb.saturated_seen);
    $display("over box, cutoff, truncation and count settings with random stalls.");
    if (sb.mismatches == 0 && sb.pending_deltas.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches,
               sb.pending_deltas.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
